// ----- hdl/tasp_pkg.sv -----
package tasp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIME = 2'd2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [6:0] UP_TIME_RST   = 7'd11;
  localparam logic [6:0] DOWN_TIME_RST = 7'd30;
  localparam logic [7:0] LOCK_TIME_RST = 8'd150;

  localparam logic [15:0] TIMER_WRAP = 16'hFFFF;

  typedef struct packed {
    logic [3:0] goal;
    logic       by_button;
    logic       limit_up;
    logic       limit_down;
    logic       tick;
    logic       clear_lock;
  } in_t;

  typedef struct packed {
    logic       drive_fwd;
    logic       drive_bwd;
    logic [3:0] position;
    logic       locked;
    logic       pause_before;
  } out_t;

  // up_time * coef / 4, coef is 10 or 12
  function automatic logic [8:0] quarter_base(input logic [6:0] up, input logic [3:0] coef);
    logic [10:0] prod;
    prod = 11'(up) * 11'(coef);
    return prod[10:2];
  endfunction

  function automatic logic [10:0] times_ten7(input logic [6:0] v);
    return 11'(v) * 11'd10;
  endfunction

  function automatic logic [11:0] times_ten8(input logic [7:0] v);
    return 12'(v) * 12'd10;
  endfunction

endpackage

// ----- hdl/timed_actuator_step_positioner_top.sv -----
// timed actuator step positioner
// input channel (in_valid/in_ready/in_data): one evaluation per transaction,
// carrying the goal step, control source, limit switches, a 10 ms tick flag
// and a lock-clear flag. each transaction yields exactly one result.
// result channel (out_valid/out_ready/out_data): drive lines, believed
// position, lock flag and the reversal pause flag.
// config port (cfg_we/cfg_index/cfg_data): 0 up_time, 1 down_time,
// 2 lock_time; other indexes are ignored. write only while the block is idle.
// a taken input transaction loads the input register; its result then loads the
// result register once that register is free, and is valid from there.
// throughput: one transaction per cycle while the result channel is not stalled.
// when out_ready is low the result register holds; an empty input register still
// takes one more transaction, then in_ready drops until the result is taken.
// reset (rst_n low, synchronous): position 0, timer stopped at 0, no drive,
// last direction backward, lock clear, registers back to 11, 30 and 150.
module timed_actuator_step_positioner_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tasp_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tasp_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [tasp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tasp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tasp_pkg::*;

  // derived config terms, scaled at write time
  logic [8:0]  base10_r, base10_nxt;
  logic [8:0]  base12_r, base12_nxt;
  logic [10:0] down10_r, down10_nxt;
  logic [11:0] lock10_r, lock10_nxt;

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        out_valid_r;
  out_t        out_data_r, out_data_nxt;
  logic        adv;

  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        en_r, en_nxt;
  logic        mf_r, mf_nxt;
  logic        mb_r, mb_nxt;
  logic        ldf_r, ldf_nxt;
  logic        lock_r, lock_nxt;

  always_comb begin
    base10_nxt = base10_r;
    base12_nxt = base12_r;
    down10_nxt = down10_r;
    lock10_nxt = lock10_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_UP_TIME: begin
          base10_nxt = quarter_base(cfg_data[6:0], 4'd10);
          base12_nxt = quarter_base(cfg_data[6:0], 4'd12);
        end
        REG_DOWN_TIME: down10_nxt = times_ten7(cfg_data[6:0]);
        REG_LOCK_TIME: lock10_nxt = times_ten8(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base10_r <= quarter_base(UP_TIME_RST, 4'd10);
      base12_r <= quarter_base(UP_TIME_RST, 4'd12);
      down10_r <= times_ten7(DOWN_TIME_RST);
      lock10_r <= times_ten8(LOCK_TIME_RST);
    end else begin
      base10_r <= base10_nxt;
      base12_r <= base12_nxt;
      down10_r <= down10_nxt;
      lock10_r <= lock10_nxt;
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  // state update for the transaction held in the input register
  always_comb begin
    logic [3:0]  pos;
    logic [15:0] t;
    logic        en, mf, mb, ldf, lk, pause;
    logic [3:0]  steps;
    logic [8:0]  base;
    logic [12:0] limit;
    logic [4:0]  sum;

    pos   = pos_r;
    t     = timer_r;
    en    = en_r;
    mf    = mf_r;
    mb    = mb_r;
    ldf   = ldf_r;
    lk    = lock_r;
    pause = 1'b0;
    steps = '0;
    base  = '0;
    limit = '0;
    sum   = '0;

    if (s1_data_r.clear_lock) lk = 1'b0;

    if (s1_data_r.tick) begin
      if (en) t = t + 16'd1;
      if (t == TIMER_WRAP) t = '0;
    end

    // forward phase
    if (s1_data_r.goal > pos || mf) begin
      steps = (s1_data_r.goal > pos) ? s1_data_r.goal - pos : 4'd1;
      if (!ldf) begin
        pause = 1'b1;
        en    = 1'b1;
        mf    = 1'b1;
        mb    = 1'b0;
        t     = '0;
        if (s1_data_r.by_button) pos = '0;
      end
      ldf   = 1'b1;
      base  = s1_data_r.by_button ? base10_r : base12_r;
      limit = 13'(base) * 13'(steps);
      if (t <= 16'(limit) && !s1_data_r.limit_up) begin
        mf = 1'b1;
        mb = 1'b0;
        en = 1'b1;
      end else begin
        if (en) begin
          sum = 5'(pos) + 5'(steps);
          pos = sum[4] ? 4'd15 : sum[3:0];
        end
        if (pos < 4'd4 || !s1_data_r.by_button) begin
          en = 1'b0;
          t  = '0;
        end
        mf = 1'b0;
        mb = 1'b0;
      end
    end

    // backward phase
    if (s1_data_r.goal < pos || mb) begin
      steps = (pos > s1_data_r.goal) ? pos - s1_data_r.goal : 4'd1;
      if (ldf) begin
        pause = 1'b1;
        en    = 1'b1;
        mb    = 1'b1;
        mf    = 1'b0;
        t     = '0;
      end
      ldf = 1'b0;
      if (s1_data_r.goal == 4'd0) limit = 13'(down10_r);
      else limit = 13'(base10_r) * 13'(steps);
      if (t <= 16'(limit) && !s1_data_r.limit_down) begin
        mb = 1'b1;
        mf = 1'b0;
        en = 1'b1;
      end else begin
        if (en) begin
          if (s1_data_r.goal == 4'd0) pos = '0;
          else pos = (pos > steps) ? pos - steps : 4'd0;
        end
        en = 1'b0;
        t  = '0;
        mf = 1'b0;
        mb = 1'b0;
      end
    end

    // a run long enough stops the timer and, under button control, engages lock
    if (t >= 16'(lock10_r)) begin
      if (s1_data_r.by_button) lk = 1'b1;
      en = 1'b0;
      t  = '0;
    end

    pos_nxt   = pos;
    timer_nxt = t;
    en_nxt    = en;
    mf_nxt    = mf;
    mb_nxt    = mb;
    ldf_nxt   = ldf;
    lock_nxt  = lk;

    out_data_nxt.drive_fwd    = mf;
    out_data_nxt.drive_bwd    = mb;
    out_data_nxt.position     = pos;
    out_data_nxt.locked       = lk;
    out_data_nxt.pause_before = pause;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      timer_r     <= '0;
      en_r        <= 1'b0;
      mf_r        <= 1'b0;
      mb_r        <= 1'b0;
      ldf_r       <= 1'b0;
      lock_r      <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
      if (s1_valid_r && adv) begin
        pos_r   <= pos_nxt;
        timer_r <= timer_nxt;
        en_r    <= en_nxt;
        mf_r    <= mf_nxt;
        mb_r    <= mb_nxt;
        ldf_r   <= ldf_nxt;
        lock_r  <= lock_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (s1_valid_r && adv) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mf_r && mb_r))
    else $error("both drive directions active");

  a_timer_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    timer_r != TIMER_WRAP)
    else $error("run timer held the wrap value");

  a_item_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv |=> out_valid_r)
    else $error("transaction lost between input and result register");

  a_lock_by_button: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lock_r) |-> $past(s1_valid_r && adv && s1_data_r.by_button))
    else $error("lock set without button control");
`endif

endmodule
